// ----- rtl/tmrf_pkg.sv -----
// tmrf_pkg: field widths, register reset value and the sorter control struct
// for the temporal median range filter; no dependencies
package tmrf_pkg;

  localparam int BEAM_W     = 9;
  localparam int BEAM_EXT_W = 13;
  localparam int RANGE_W    = 16;
  localparam int USED_W     = 4;
  localparam int WLEN_W     = 4;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd5;

  // control group from the sequencer to the sorter
  typedef struct packed {
    logic               load;
    logic               ins;
    logic [RANGE_W-1:0] value;
  } sort_ctrl_t;

endpackage

// ----- rtl/tmrf_sorter.sv -----
// tmrf_sorter: insertion sort register array and median select
// depends on tmrf_pkg
module tmrf_sorter #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                                   clk,
  input  tmrf_pkg::sort_ctrl_t                   ctrl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        n,
  output logic [tmrf_pkg::RANGE_W-1:0]           median
);
  import tmrf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW+1);
  localparam int SW = $clog2(MAX_WINDOW);

  logic [RANGE_W-1:0] s      [MAX_WINDOW];
  logic [RANGE_W-1:0] s_next [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] keep;
  logic [CW-1:0] len;
  logic [CW-1:0] half;
  logic [SW-1:0] idx_hi;
  logic [SW-1:0] idx_lo;
  logic [RANGE_W:0] pair_sum;

  // entries at or past len count as larger than any value
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      keep[i] = (CW'(i) < len) && (s[i] <= ctrl.value);
    end
    s_next[0] = keep[0] ? s[0] : ctrl.value;
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if (keep[i]) begin
        s_next[i] = s[i];
      end else if (keep[i-1]) begin
        s_next[i] = ctrl.value;
      end else begin
        s_next[i] = s[i-1];
      end
    end
  end

  // load starts a fresh list, insert adds one sample in place
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s[0] <= ctrl.value;
      len  <= CW'(1);
    end else if (ctrl.ins) begin
      s   <= s_next;
      len <= len + CW'(1);
    end
  end

  // middle value, or floor of the mean of the two middle values
  always_comb begin
    half     = n >> 1;
    idx_hi   = half[SW-1:0];
    idx_lo   = idx_hi - SW'(1);
    pair_sum = {1'b0, s[idx_hi]} + {1'b0, s[idx_lo]};
    median   = n[0] ? s[idx_hi] : pair_sum[RANGE_W:1];
  end

endmodule

// ----- rtl/temporal_median_range_filter.sv -----
// temporal_median_range_filter: per-beam temporal median over a ring of samples
// depends on tmrf_pkg and tmrf_sorter
//
//   channel  signals                                       direction
//   cfg      cfg_valid cfg_ready cfg_data                  in (window_length)
//   in       in_valid in_ready beam_index range_value      in
//   out      out_valid out_ready beam_out median_range     out
//            samples_used
//
// an item with n samples passes from accept to the next accept through the meta read, n - 1
// history reads, last insert, select, output load and idle; with one sample the reads and the
// last insert are skipped. a beam index at or above NUM_BEAMS goes straight to the finish
// step and touches neither memory. after reset a clearing pass over all NUM_BEAMS entries
// zeroes the fill count and write slot memory; no item is accepted then, config writes are.
// the result waits in an output register; a stalled output holds the next
// item in the finish step until the register frees.
module temporal_median_range_filter #(
  parameter int NUM_BEAMS  = 512,
  parameter int MAX_WINDOW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmrf_pkg::WLEN_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmrf_pkg::BEAM_W-1:0]   beam_index,
  input  logic [tmrf_pkg::RANGE_W-1:0]  range_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmrf_pkg::BEAM_W-1:0]   beam_out,
  output logic [tmrf_pkg::RANGE_W-1:0]  median_range,
  output logic [tmrf_pkg::USED_W-1:0]   samples_used
);
  import tmrf_pkg::*;

  localparam int BW  = (NUM_BEAMS > 1) ? $clog2(NUM_BEAMS) : 1;
  localparam int CW  = $clog2(MAX_WINDOW+1);
  localparam int SW  = $clog2(MAX_WINDOW);
  localparam int MW  = CW + SW;
  localparam int HD  = NUM_BEAMS * MAX_WINDOW;
  localparam int HAW = $clog2(HD);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_META   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_LAST   = 7'b0010000,
    S_SELECT = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [WLEN_W-1:0]  window_length;
  logic [CW-1:0]      win_eff;
  logic [BW-1:0]      clr_addr;
  logic [BEAM_W-1:0]  beam_q;
  logic [RANGE_W-1:0] range_q;
  logic [HAW-1:0]     hist_base;
  logic [SW-1:0]      rd_slot;
  logic [CW-1:0]      rd_k;
  logic [CW-1:0]      n_q;
  logic               pend;
  logic [RANGE_W-1:0] med;
  logic [7:0]         n_wide;

  logic               in_acc;
  logic               beam_ok;
  logic [BEAM_EXT_W-1:0] beam_in_ext;
  logic [BEAM_EXT_W-1:0] beam_q_ext;

  // fill count and write slot memory
  logic [MW-1:0] meta_mem [NUM_BEAMS];
  logic [MW-1:0] meta_rdata;
  logic [MW-1:0] meta_wdata;
  logic [BW-1:0] meta_raddr;
  logic [BW-1:0] meta_waddr;
  logic          meta_we;
  logic [CW-1:0] cur_count;
  logic [SW-1:0] cur_slot;
  logic [CW-1:0] count_new;
  logic [SW-1:0] slot_inc;
  logic [SW-1:0] slot_dec;
  logic [CW-1:0] n_comb;

  // history memory
  logic [RANGE_W-1:0] hist_mem [HD];
  logic [RANGE_W-1:0] hist_rdata;
  logic [HAW-1:0]     hist_raddr;
  logic [HAW-1:0]     hist_waddr;
  logic               hist_we;

  sort_ctrl_t         sort_ctrl;
  logic [RANGE_W-1:0] sort_median;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign beam_in_ext = BEAM_EXT_W'(beam_index);
  assign beam_q_ext  = BEAM_EXT_W'(beam_q);
  assign beam_ok     = int'(beam_index) < NUM_BEAMS;

  // window register clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      win_eff = CW'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(window_length);
    end
  end

  // per-beam update from the meta read
  always_comb begin
    cur_count = meta_rdata[MW-1:SW];
    cur_slot  = meta_rdata[SW-1:0];
    count_new = (cur_count < CW'(MAX_WINDOW)) ? cur_count + CW'(1) : cur_count;
    slot_inc  = (cur_slot == SW'(MAX_WINDOW-1)) ? '0 : cur_slot + SW'(1);
    slot_dec  = (cur_slot == '0) ? SW'(MAX_WINDOW-1) : cur_slot - SW'(1);
    n_comb    = (count_new < win_eff) ? count_new : win_eff;
  end

  // meta port control: clearing pass or write-back of the current beam
  always_comb begin
    meta_raddr = beam_in_ext[BW-1:0];
    meta_we    = (state == S_CLEAR) || (state == S_META);
    meta_waddr = (state == S_CLEAR) ? clr_addr : beam_q_ext[BW-1:0];
    meta_wdata = (state == S_CLEAR) ? '0 : {count_new, slot_inc};
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

  // history port: new sample written at the meta step, older ones read after
  assign hist_we    = (state == S_META);
  assign hist_waddr = hist_base + HAW'(cur_slot);
  assign hist_raddr = hist_base + HAW'(rd_slot);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= range_q;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  // sorter feed
  always_comb begin
    sort_ctrl.load  = (state == S_META);
    sort_ctrl.ins   = ((state == S_READ) && pend) || (state == S_LAST);
    sort_ctrl.value = sort_ctrl.load ? range_q : hist_rdata;
  end

  tmrf_sorter #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_sorter (
    .clk    (clk),
    .ctrl   (sort_ctrl),
    .n      (n_q),
    .median (sort_median)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == BW'(NUM_BEAMS-1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_next = beam_ok ? S_META : S_FINISH;
      end
      S_META: begin
        state_next = (n_comb == CW'(1)) ? S_SELECT : S_READ;
      end
      S_READ: begin
        if (rd_k == n_q - CW'(1)) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_SELECT;
      end
      S_SELECT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      window_length <= WLEN_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + BW'(1);
      if (cfg_valid && cfg_ready) window_length <= cfg_data;
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          beam_q    <= beam_index;
          range_q   <= range_value;
          hist_base <= HAW'(int'(beam_in_ext) * MAX_WINDOW);
          med       <= range_value;
          n_q       <= CW'(1);
        end
      end
      S_META: begin
        n_q     <= n_comb;
        rd_k    <= CW'(1);
        rd_slot <= slot_dec;
        pend    <= 1'b0;
      end
      S_READ: begin
        rd_k    <= rd_k + CW'(1);
        rd_slot <= (rd_slot == '0) ? SW'(MAX_WINDOW-1) : rd_slot - SW'(1);
        pend    <= 1'b1;
      end
      S_SELECT: begin
        med <= sort_median;
      end
      default: begin
      end
    endcase
  end

  // output register
  assign n_wide = 8'(n_q);

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      beam_out     <= beam_q;
      median_range <= med;
      samples_used <= n_wide[USED_W-1:0];
    end
  end

endmodule

// ----- rtl/tmrf_checker.sv -----
// tmrf_checker: port-level assertions for the temporal median range filter
// depends on tmrf_pkg; bound to temporal_median_range_filter below
module tmrf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tmrf_pkg::BEAM_W-1:0]   beam_out,
  input logic [tmrf_pkg::RANGE_W-1:0]  median_range,
  input logic [tmrf_pkg::USED_W-1:0]   samples_used
);
  import tmrf_pkg::*;

  // the clearing pass blocks items right after reset
  a_clear_after_reset: assert property (
    @(posedge clk) ($past(rst) && !rst) |-> !in_ready
  ) else $error("item accepted during clearing pass");

  // one item at a time
  a_one_item: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("second item accepted while one is at work");

  // no result shows in the cycle after an accept unless one was waiting
  a_no_early_result: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid || $past(out_valid))
  ) else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(beam_out) && $stable(median_range) && $stable(samples_used))
  ) else $error("stalled result changed");

endmodule

bind temporal_median_range_filter tmrf_checker u_tmrf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .beam_out     (beam_out),
  .median_range (median_range),
  .samples_used (samples_used)
);

// ----- tb/temporal_median_range_filter_tb.sv -----
// temporal_median_range_filter_tb: self-checking bench for the per-beam temporal median filter
// depends on tmrf_pkg and the temporal_median_range_filter rtl; predicts every median in
// sv and checks each output item against the oldest pending prediction
`timescale 1ns / 1ps

module temporal_median_range_filter_tb;
  import tmrf_pkg::*;

  localparam int BEAM_COUNT  = 512;
  localparam int HIST_DEPTH  = 8;
  localparam int SETTLE_CYC  = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 160;

  localparam logic [WLEN_W-1:0] WLEN_ZERO = 4'd0;
  localparam logic [WLEN_W-1:0] WLEN_MIN  = 4'd1;
  localparam logic [WLEN_W-1:0] WLEN_FULL = 4'd8;
  localparam logic [WLEN_W-1:0] WLEN_OVER = 4'd9;
  localparam logic [WLEN_W-1:0] WLEN_TOP  = 4'd15;

  typedef struct {
    logic [BEAM_W-1:0]  beam;
    logic [RANGE_W-1:0] range_mm;
  } scan_sample_t;

  typedef struct {
    logic [BEAM_W-1:0]  beam;
    logic [RANGE_W-1:0] median;
    logic [USED_W-1:0]  used;
  } beam_median_t;

  logic clk;
  logic rst = 1'b1;

  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [WLEN_W-1:0]  cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [BEAM_W-1:0]  beam_index  = '0;
  logic [RANGE_W-1:0] range_value = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [BEAM_W-1:0]  beam_out;
  logic [RANGE_W-1:0] median_range;
  logic [USED_W-1:0]  samples_used;

  // per-beam history, fill count and write slot as the block keeps them
  logic [RANGE_W-1:0] ring_mm [BEAM_COUNT][HIST_DEPTH];
  int                 fill_count [BEAM_COUNT];
  int                 write_slot [BEAM_COUNT];
  logic [WLEN_W-1:0]  window_reg = WLEN_RESET;

  scan_sample_t scan_samples[$];
  beam_median_t pending_medians[$];
  scan_sample_t next_sample;
  beam_median_t got_median;
  beam_median_t want_median;

  int send_idle_pct  = 17;
  int recv_stall_pct = 17;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  temporal_median_range_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .beam_index   (beam_index),
    .range_value  (range_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .beam_out     (beam_out),
    .median_range (median_range),
    .samples_used (samples_used)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // store the sample, then take the median of the newest min(fill, window) samples
  function automatic beam_median_t filter_sample(logic [BEAM_W-1:0] beam,
                                                 logic [RANGE_W-1:0] range_mm);
    logic [RANGE_W-1:0] picked [HIST_DEPTH];
    logic [RANGE_W-1:0] key;
    logic [RANGE_W:0]   pair_sum;
    int                 b, slot, n, eff, i, j;
    beam_median_t       res;
    b        = int'(beam);
    res.beam = beam;
    if (b >= BEAM_COUNT) begin
      res.median = range_mm;
      res.used   = USED_W'(1);
      return res;
    end
    slot              = write_slot[b] % HIST_DEPTH;
    ring_mm[b][slot]  = range_mm;
    write_slot[b]     = (slot + 1) % HIST_DEPTH;
    if (fill_count[b] < HIST_DEPTH) fill_count[b]++;
    eff = int'(window_reg);
    if (eff < 1) eff = 1;
    if (eff > HIST_DEPTH) eff = HIST_DEPTH;
    n = (fill_count[b] < eff) ? fill_count[b] : eff;
    for (i = 0; i < n; i++) picked[i] = ring_mm[b][(slot + HIST_DEPTH - i) % HIST_DEPTH];
    // insertion sort, ascending
    for (i = 1; i < n; i++) begin
      key = picked[i];
      j = i;
      while (j > 0 && picked[j-1] > key) begin
        picked[j] = picked[j-1];
        j--;
      end
      picked[j] = key;
    end
    if (n % 2 == 1) begin
      res.median = picked[n/2];
    end else begin
      pair_sum   = {1'b0, picked[n/2-1]} + {1'b0, picked[n/2]};
      res.median = pair_sum[RANGE_W:1];
    end
    res.used = n[USED_W-1:0];
    return res;
  endfunction

  // input driver: predict on accept, then present the next queued item or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_medians.insert(pending_medians.size(), filter_sample(beam_index, range_value));
      end
      if (!in_valid || in_ready) begin
        if (scan_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = scan_samples.pop_front();
          in_valid    <= 1'b1;
          beam_index  <= next_sample.beam;
          range_value <= next_sample.range_mm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: check each accepted item against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_median.beam   = beam_out;
        got_median.median = median_range;
        got_median.used   = samples_used;
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected item beam_out %0d median_range %0d samples_used %0d",
                   $time, beam_out, median_range, samples_used);
          mismatches++;
        end else begin
          want_median = pending_medians.pop_front();
          if (got_median.beam !== want_median.beam) begin
            $display("%0t: beam_out expected %0d actual %0d",
                     $time, want_median.beam, got_median.beam);
            mismatches++;
          end
          if (got_median.median !== want_median.median) begin
            $display("%0t: median_range (beam %0d) expected %0d actual %0d",
                     $time, want_median.beam, want_median.median, got_median.median);
            mismatches++;
          end
          if (got_median.used !== want_median.used) begin
            $display("%0t: samples_used (beam %0d) expected %0d actual %0d",
                     $time, want_median.beam, want_median.used, got_median.used);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_sample(int beam, int range_mm);
    scan_sample_t s;
    s.beam     = beam[BEAM_W-1:0];
    s.range_mm = range_mm[RANGE_W-1:0];
    scan_samples.insert(scan_samples.size(), s);
  endtask

  // hold until every queued item went in and every prediction was matched
  task automatic wait_drained();
    while (scan_samples.size() != 0 || in_valid || pending_medians.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_window(logic [WLEN_W-1:0] wlen);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= wlen;
    do @(posedge clk); while (!cfg_ready);
    window_reg = wlen;
    cfg_valid <= 1'b0;
  endtask

  // mostly a few hot beams so rings fill and wrap; ranges lean on extremes and ties
  task automatic add_random_sample();
    int pick, beam, range_mm;
    pick = $urandom_range(99);
    if (pick < 5)       beam = BEAM_COUNT - 1 - $urandom_range(3);
    else if (pick < 75) beam = $urandom_range(15);
    else                beam = $urandom_range(BEAM_COUNT - 1);
    pick = $urandom_range(99);
    if (pick < 10)      range_mm = $urandom_range(1) ? 16'hFFFF : 0;
    else if (pick < 40) range_mm = 1000 + $urandom_range(7);
    else if (pick < 50) range_mm = 16'hFFF0 + $urandom_range(15);
    else                range_mm = $urandom_range(16'hFFFF);
    add_sample(beam, range_mm);
  endtask

  initial begin
    logic [WLEN_W-1:0] phase_window [12];
    int p, k;
    phase_window = '{WLEN_MIN, WLEN_FULL, 4'd3, WLEN_ZERO, WLEN_TOP, 4'd4,
                     WLEN_OVER, 4'd6, 4'd7, 4'd2, WLEN_RESET, WLEN_FULL};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset window, extremes, even counts, ring growth
    add_sample(0, 16'hFFFF);
    add_sample(0, 16'hFFFE);
    add_sample(0, 0);
    add_sample(0, 16'hFFFF);
    add_sample(0, 1);
    add_sample(0, 2);
    add_sample(BEAM_COUNT - 1, 0);
    add_sample(BEAM_COUNT - 1, 16'hFFFF);
    add_sample(256, 16'hAAAA);
    add_sample(256, 16'h5555);
    wait_drained();

    // full window, fill saturates and the ring wraps
    write_window(WLEN_FULL);
    add_sample(0, 16'h8000);
    add_sample(0, 16'h7FFF);
    add_sample(0, 16'hFFFF);
    wait_drained();

    // zero window acts as one
    write_window(WLEN_ZERO);
    add_sample(0, 12345);
    add_sample(BEAM_COUNT - 1, 16'hFFFF);
    wait_drained();

    // oversized window saturates
    write_window(WLEN_TOP);
    add_sample(0, 0);
    add_sample(BEAM_COUNT - 1, 7);
    wait_drained();

    // window shrunk after use: newest samples only
    write_window(4'd2);
    add_sample(0, 16'hFFFF);
    add_sample(0, 16'hFFFE);
    wait_drained();

    write_window(WLEN_OVER);
    add_sample(BEAM_COUNT - 1, 16'h1234);
    wait_drained();

    // random phases, one per window setting; one phase runs with no idling
    for (p = 0; p < 12; p++) begin
      write_window(phase_window[p]);
      send_idle_pct  = (p == 7) ? 0 : 17;
      recv_stall_pct = (p == 7) ? 0 : 17;
      for (k = 0; k < PHASE_ITEMS; k++) add_random_sample();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
